// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker in putp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts that an implication holds at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Asserts that an implication holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/putp_pkg.sv =====
package putp_pkg;

  localparam int unsigned MantW = 32;
  localparam int unsigned ExpW = 16;
  localparam int unsigned TaylorW = 45;
  localparam int unsigned TaylorTerms = 16;
  localparam int unsigned UnderflowInt = 745;
  localparam logic [31:0] OneQ31 = 32'h8000_0000;
  localparam logic [62:0] OneQ62 = 63'h4000_0000_0000_0000;

  typedef enum logic [3:0] {
    StIdle,
    StExpInit,
    StExpStep,
    StExpDiv,
    StExpDiff,
    StExpNorm,
    StPowStep,
    StPowNorm,
    StLoopAdd,
    StLoopMul,
    StLoopMulNorm,
    StLoopDiv,
    StLoopDivNorm,
    StFinish,
    StOut
  } putp_state_e;

  typedef enum logic [3:0] {
    CmdNone,
    CmdLoad,
    CmdExpInit,
    CmdExpStep,
    CmdExpAcc,
    CmdExpDiff,
    CmdExpNorm,
    CmdPowStep,
    CmdPowNorm,
    CmdAdd,
    CmdMul,
    CmdMulNorm,
    CmdDivInit,
    CmdDivStep,
    CmdDivNorm,
    CmdFinish
  } putp_cmd_e;

  typedef struct packed {
    logic trivial;
    logic underflow;
    logic taylor_done;
    logic exp_second;
    logic pow_done;
    logic norm_done;
    logic loop_done;
    logic term_zero;
    logic div_done;
  } putp_status_t;

endpackage

// ===== sv/putp_datapath.sv =====
module putp_datapath
  import putp_pkg::*;
#(
  parameter int unsigned MaxFragments = 255,
  parameter int unsigned PeakCountBits = 12,
  localparam int unsigned NW = $clog2(MaxFragments + 1) + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  putp_cmd_e                cmd_i,
  input  logic [PeakCountBits-1:0] peak_count_i,
  input  logic [15:0]              match_prob_i,
  input  logic [7:0]               matched_fragments_i,
  input  logic [3:0]               unexpected_shifts_i,
  input  logic [3:0]               shift_cost_i,
  output putp_status_t             status_o,
  output logic [31:0]              tail_prob_o,
  output logic                     trivial_case_o
);

  localparam int unsigned LamW = PeakCountBits + 16;
  localparam int unsigned KW = PeakCountBits;

  logic [LamW-1:0]    lambda_q, lambda_d;
  logic [KW-1:0]      k_q, k_d;
  logic [NW-1:0]      n_q, n_d, i_q, i_d;
  logic [NW-1:0]      dvs_q, dvs_d;
  logic               trivial_q, trivial_d;
  logic               second_q, second_d;
  logic [4:0]         j_q, j_d;
  logic [TaylorW-1:0] tterm_q, tterm_d, pos_q, pos_d, neg_q, neg_d;
  logic [16:0]        targ_q, targ_d;
  logic [63:0]        am_q, am_d;
  logic signed [ExpW-1:0] ae_q, ae_d;
  logic [31:0]        tm_q, tm_d, bm_q, bm_d;
  logic signed [ExpW-1:0] te_q, te_d, be_q, be_d;
  logic               pstage_q, pstage_d;
  logic [62:0]        sum_q, sum_d;
  logic [5:0]         dcnt_q, dcnt_d;
  logic [62:0]        rem_q, rem_d;
  logic [31:0]        tail_q, tail_d;
  logic               triv_out_q, triv_out_d;

  logic signed [10:0] n_full;
  logic [LamW-1:0]    lam_full;
  logic [61:0]        prod_t;
  logic signed [ExpW:0] s_q62;
  logic [62:0]        q62;
  logic [63:0]        sum_w;
  logic [63:0]        ext_m;
  logic [TaylorW-1:0] tdiff;
  logic [62:0]        rem_sh;
  logic [31:0]        half;

  always_comb begin
    n_full = $signed({3'b000, matched_fragments_i})
           - $signed({3'b000, 8'(unexpected_shifts_i) * 8'(shift_cost_i)});
    lam_full = LamW'(match_prob_i) * LamW'(peak_count_i);
    prod_t = 62'(tterm_q) * 62'(targ_q);
    tdiff = (pos_q > neg_q) ? pos_q - neg_q : '0;
    s_q62 = (ExpW+1)'(te_q) + (ExpW+1)'(62);
    if (tm_q == '0 || s_q62 <= -64) begin
      q62 = '0;
    end else if (s_q62 >= 0) begin
      q62 = (s_q62 > 31) ? OneQ62 : 63'(tm_q) << s_q62[4:0];
    end else begin
      q62 = 63'(tm_q) >> 6'(-s_q62);
    end
    sum_w = 64'(sum_q) + 64'(q62);
    ext_m = 64'(tm_q) * 64'(bm_q);
    rem_sh = {rem_q[61:0], am_q[63]};
    half = 32'(sum_q >> 31);
  end

  always_comb begin
    lambda_d = lambda_q; k_d = k_q; n_d = n_q; i_d = i_q; dvs_d = dvs_q;
    trivial_d = trivial_q; second_d = second_q; j_d = j_q;
    tterm_d = tterm_q; pos_d = pos_q; neg_d = neg_q; targ_d = targ_q;
    am_d = am_q; ae_d = ae_q; tm_d = tm_q; te_d = te_q; bm_d = bm_q; be_d = be_q;
    pstage_d = pstage_q; sum_d = sum_q; dcnt_d = dcnt_q; rem_d = rem_q;
    tail_d = tail_q; triv_out_d = triv_out_q;
    unique case (cmd_i)
      CmdLoad: begin
        lambda_d = lam_full;
        k_d = KW'(lam_full >> 16);
        trivial_d = (peak_count_i == '0) || (match_prob_i == '0)
          || (n_full <= 0);
        n_d = (n_full > $signed(11'(MaxFragments))) ? NW'(MaxFragments)
            : NW'(n_full);
        i_d = '0;
        sum_d = '0;
        second_d = 1'b0;
        pstage_d = 1'b0;
      end
      CmdExpInit: begin
        tterm_d = TaylorW'(1) << 44;
        pos_d = TaylorW'(1) << 44;
        neg_d = '0;
        j_d = 5'd1;
        targ_d = second_q ? 17'h10000 : {1'b0, lambda_q[15:0]};
      end
      CmdExpStep: begin
        am_d = 64'(prod_t >> 16) << 18;
        rem_d = '0;
        dcnt_d = 6'd17;
        dvs_d = NW'(j_q);
      end
      CmdExpAcc: begin
        tterm_d = am_q[TaylorW-1:0];
        if (j_q[0]) neg_d = neg_q + am_q[TaylorW-1:0];
        else pos_d = pos_q + am_q[TaylorW-1:0];
        j_d = j_q + 5'd1;
      end
      CmdExpDiff: begin
        am_d = 64'(tdiff);
        ae_d = -ExpW'(44);
      end
      CmdExpNorm, CmdPowNorm, CmdMulNorm, CmdDivNorm: begin
        if (am_q[63:32] != '0) begin
          am_d = am_q >> 1;
          ae_d = ae_q + ExpW'(1);
        end else if (am_q != '0 && !am_q[31]) begin
          am_d = am_q << 1;
          ae_d = ae_q - ExpW'(1);
        end else begin
          if (cmd_i == CmdExpNorm) begin
            if (second_q) begin
              bm_d = am_q[31:0];
              be_d = (am_q == '0) ? '0 : ae_q;
            end else begin
              tm_d = am_q[31:0];
              te_d = (am_q == '0) ? '0 : ae_q;
            end
            second_d = 1'b1;
          end else if (cmd_i == CmdPowNorm) begin
            if (pstage_q) begin
              bm_d = am_q[31:0];
              be_d = (am_q == '0) ? '0 : ae_q;
              k_d = k_q >> 1;
            end else begin
              tm_d = am_q[31:0];
              te_d = (am_q == '0) ? '0 : ae_q;
            end
            pstage_d = ~pstage_q;
          end else begin
            tm_d = am_q[31:0];
            te_d = (am_q == '0) ? '0 : ae_q;
            if (cmd_i == CmdDivNorm) i_d = i_q + NW'(1);
          end
        end
      end
      CmdPowStep: begin
        if (pstage_q) begin
          am_d = 64'(bm_q) * 64'(bm_q);
          ae_d = be_q + be_q;
        end else if (k_q[0]) begin
          am_d = ext_m;
          ae_d = te_q + be_q;
        end else begin
          am_d = {32'h0, tm_q};
          ae_d = te_q;
        end
      end
      CmdAdd: begin
        sum_d = (sum_w > 64'(OneQ62)) ? OneQ62 : sum_w[62:0];
      end
      CmdMul: begin
        am_d = 64'(tm_q) * 64'(lambda_q);
        ae_d = te_q - ExpW'(16);
      end
      CmdDivInit: begin
        rem_d = '0;
        am_d = {tm_q, 32'h0};
        ae_d = te_q - ExpW'(31);
        dcnt_d = '0;
        dvs_d = i_q + NW'(1);
      end
      CmdDivStep: begin
        am_d = {am_q[62:0], 1'b0};
        if (rem_sh >= 63'(dvs_q)) begin
          rem_d = rem_sh - 63'(dvs_q);
          am_d[0] = 1'b1;
        end else begin
          rem_d = rem_sh;
        end
        dcnt_d = dcnt_q + 6'd1;
      end
      CmdFinish: begin
        triv_out_d = trivial_q;
        if (trivial_q) tail_d = OneQ31;
        else tail_d = (half >= OneQ31) ? '0 : OneQ31 - half;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
      pstage_q <= 1'b0;
      dcnt_q <= '0;
      i_q <= '0;
      j_q <= '0;
    end else begin
      second_q <= second_d;
      pstage_q <= pstage_d;
      dcnt_q <= dcnt_d;
      i_q <= i_d;
      j_q <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lambda_q <= lambda_d; k_q <= k_d; n_q <= n_d; trivial_q <= trivial_d;
    tterm_q <= tterm_d; pos_q <= pos_d; neg_q <= neg_d; targ_q <= targ_d;
    am_q <= am_d; ae_q <= ae_d; tm_q <= tm_d; te_q <= te_d;
    bm_q <= bm_d; be_q <= be_d; sum_q <= sum_d; rem_q <= rem_d;
    tail_q <= tail_d; triv_out_q <= triv_out_d; dvs_q <= dvs_d;
  end

  assign status_o.trivial = trivial_q;
  assign status_o.underflow = 32'(k_q) >= 32'(UnderflowInt);
  assign status_o.taylor_done = j_q == 5'(TaylorTerms);
  assign status_o.exp_second = second_q;
  assign status_o.pow_done = k_q == '0;
  assign status_o.norm_done = (am_q[63:32] == '0) && (am_q == '0 || am_q[31]);
  assign status_o.loop_done = i_q >= n_q;
  assign status_o.term_zero = tm_q == '0;
  assign status_o.div_done = dcnt_q == 6'd63;
  assign tail_prob_o = tail_q;
  assign trivial_case_o = triv_out_q;

endmodule

// ===== sv/putp_ctrl.sv =====
module putp_ctrl
  import putp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  putp_status_t status_i,
  output putp_cmd_e    cmd_o
);

  putp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = CmdNone;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o = CmdLoad;
          state_d = StExpInit;
        end
      end
      StExpInit: begin
        if (status_i.trivial || status_i.underflow) begin
          state_d = StFinish;
        end else begin
          cmd_o = CmdExpInit;
          state_d = StExpStep;
        end
      end
      StExpStep: begin
        cmd_o = CmdExpStep;
        state_d = StExpDiv;
      end
      StExpDiv: begin
        if (!status_i.div_done) begin
          cmd_o = CmdDivStep;
        end else begin
          cmd_o = CmdExpAcc;
          state_d = status_i.taylor_done ? StExpDiff : StExpStep;
        end
      end
      StExpDiff: begin
        cmd_o = CmdExpDiff;
        state_d = StExpNorm;
      end
      StExpNorm: begin
        cmd_o = CmdExpNorm;
        if (status_i.norm_done) begin
          state_d = status_i.exp_second ? StPowStep : StExpInit;
        end
      end
      StPowStep: begin
        if (status_i.pow_done) begin
          state_d = StLoopAdd;
        end else begin
          cmd_o = CmdPowStep;
          state_d = StPowNorm;
        end
      end
      StPowNorm: begin
        cmd_o = CmdPowNorm;
        if (status_i.norm_done) state_d = StPowStep;
      end
      StLoopAdd: begin
        if (status_i.loop_done) begin
          state_d = StFinish;
        end else begin
          cmd_o = CmdAdd;
          state_d = status_i.term_zero ? StFinish : StLoopMul;
        end
      end
      StLoopMul: begin
        cmd_o = CmdMul;
        state_d = StLoopMulNorm;
      end
      StLoopMulNorm: begin
        cmd_o = CmdMulNorm;
        if (status_i.norm_done) state_d = StLoopDiv;
      end
      StLoopDiv: begin
        cmd_o = CmdDivInit;
        state_d = StLoopDivNorm;
      end
      StLoopDivNorm: begin
        if (!status_i.div_done) begin
          cmd_o = CmdDivStep;
        end else begin
          cmd_o = CmdDivNorm;
          if (status_i.norm_done) state_d = StLoopAdd;
        end
      end
      StFinish: begin
        cmd_o = CmdFinish;
        state_d = StOut;
      end
      StOut: begin
        out_valid = 1'b1;
        if (!out_stall) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// ===== sv/poisson_upper_tail_prob.sv =====
// Poisson upper-tail probability for peptide spectrum match scoring.
// The input channel (in_valid/in_stall) takes one word per item: peak count,
// match probability (Q0.16), matched fragments and unexpected shifts.
// The output channel (out_valid/out_stall) returns tail_prob_o in Q1.31 and
// trivial_case_o for each item, in order.
// The user is to write the shift cost register through cfg_we_i/cfg_wdata_i
// only while idle; the block does not enforce this. One item is worked at a
// time, so in_stall is low only while the block idles. A trivial or
// underflowing item goes from StExpInit straight to StFinish and StOut.
// Otherwise each of the two exponentials is summed from Taylor terms with a
// bit-serial divide, then the square-and-multiply power is formed, and then
// each term of the sum is worked, mostly in the bit-serial divider, for up
// to n terms with n capped at MaxFragments.
// While the result waits under out_stall, it holds and in_stall stays high.
// The next word is taken in the cycle after the result is taken.
// Reset sets the shift cost to one and leaves the block idle with no result.
module poisson_upper_tail_prob
  import putp_pkg::*;
#(
  parameter int unsigned MaxFragments = 255,
  parameter int unsigned PeakCountBits = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PeakCountBits-1:0] peak_count_i,
  input  logic [15:0]              match_prob_i,
  input  logic [7:0]               matched_fragments_i,
  input  logic [3:0]               unexpected_shifts_i,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [31:0]              tail_prob_o,
  output logic                     trivial_case_o,
  input  logic                     cfg_we_i,
  input  logic [3:0]               cfg_wdata_i
);

  logic [3:0]   shift_cost_q;
  putp_cmd_e    cmd;
  putp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_cost_q <= 4'd1;
    end else if (cfg_we_i) begin
      shift_cost_q <= cfg_wdata_i;
    end
  end

  putp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .status_i(status), .cmd_o(cmd)
  );

  putp_datapath #(
    .MaxFragments(MaxFragments), .PeakCountBits(PeakCountBits)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .peak_count_i, .match_prob_i,
    .matched_fragments_i, .unexpected_shifts_i,
    .shift_cost_i(shift_cost_q), .status_o(status),
    .tail_prob_o, .trivial_case_o
  );

endmodule

// ===== sv/putp_checker.sv =====
`include "assert_macros.svh"
module putp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] tail_prob_o,
  input logic        trivial_case_o
);

  `ASSERT_IMPLIES(a_range, clk_i, rst_ni, out_valid, tail_prob_o <= 32'h8000_0000, "range")
  `ASSERT_IMPLIES(a_triv, clk_i, rst_ni, out_valid && trivial_case_o, tail_prob_o == 32'h8000_0000, "trivial")
  `ASSERT_IMPLIES(a_excl, clk_i, rst_ni, out_valid, in_stall, "busy while result waits")
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && out_stall, out_valid && $stable(tail_prob_o), "hold")

endmodule

bind poisson_upper_tail_prob putp_checker u_putp_checker (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
  .tail_prob_o, .trivial_case_o
);
